/* hw/rtl/lav_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package lav_pkg;

   localparam int DATA_W   = 32;
   localparam int FRAC_W   = 16;
   // unit component in signed q2.16, range -1.0 .. 1.0
   localparam int UNIT_W   = FRAC_W + 2;
   // magnitude of target - eye
   localparam int D_MAG_W  = DATA_W + 1;
   // magnitude of forward x up in q32.32
   localparam int C_MAG_W  = 49;
   // normalized magnitude lies in [2^30, 2^31)
   localparam int NORM_W   = 31;

   localparam logic [DATA_W-1:0] ONE_Q16  = DATA_W'(1 << FRAC_W);
   localparam logic [DATA_W-1:0] RND_HALF = DATA_W'(1 << (FRAC_W - 1));

   // right vector counts as zero length at or below this squared length
   localparam int SMALL_W = 13;
   localparam int SSUM_W  = 2 * SMALL_W + 2;
   localparam logic [SSUM_W-1:0] RIGHT_EPS_SQ = SSUM_W'(18446744);

   typedef enum logic [1:0] {
      ROW_RIGHT = 2'd0,
      ROW_UP    = 2'd1,
      ROW_FWD   = 2'd2,
      ROW_W     = 2'd3
   } row_type;

   typedef logic [2:0][UNIT_W-1:0] unit_vec_type;

endpackage
`default_nettype wire

/* hw/rtl/lav_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface lav_req_if;
   import lav_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] eye_x;
   logic signed [DATA_W-1:0] eye_y;
   logic signed [DATA_W-1:0] eye_z;
   logic signed [DATA_W-1:0] target_x;
   logic signed [DATA_W-1:0] target_y;
   logic signed [DATA_W-1:0] target_z;
   logic signed [DATA_W-1:0] world_up_x;
   logic signed [DATA_W-1:0] world_up_y;
   logic signed [DATA_W-1:0] world_up_z;

   modport source (
      output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
      output world_up_x, world_up_y, world_up_z,
      input  ready
   );

   modport sink (
      input  valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
      input  world_up_x, world_up_y, world_up_z,
      output ready
   );

endinterface
`default_nettype wire

/* hw/rtl/lav_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface lav_rsp_if;
   import lav_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [1:0]               row_index;
   logic signed [DATA_W-1:0] col0;
   logic signed [DATA_W-1:0] col1;
   logic signed [DATA_W-1:0] col2;
   logic signed [DATA_W-1:0] col3;
   logic                     last_row;
   logic                     degenerate;

   modport source (
      output valid, row_index, col0, col1, col2, col3, last_row, degenerate,
      input  ready
   );

   modport sink (
      input  valid, row_index, col0, col1, col2, col3, last_row, degenerate,
      output ready
   );

endinterface
`default_nettype wire

/* hw/rtl/lav_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// pipelined vector normalize: scale, sum of squares, bit-serial sqrt, divide
module lav_unit #(
   parameter int MagW = lav_pkg::D_MAG_W,
   parameter int TagW = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic [2:0][MagW-1:0]  in_mag,
   input  logic [2:0]            in_neg,
   input  logic [TagW-1:0]       in_tag,
   output logic                  out_valid,
   output lav_pkg::unit_vec_type out_unit,
   output logic [TagW-1:0]       out_tag
);
   import lav_pkg::*;

   localparam int PosW     = $clog2(MagW);
   localparam int WideW    = MagW + NORM_W - 1;
   localparam int SqW      = 2 * NORM_W;
   localparam int SumW     = 64;
   localparam int RootW    = SumW / 2;
   localparam int RemW     = RootW + 4;
   localparam int NumW     = NORM_W + FRAC_W + 1;
   localparam int QuoW     = FRAC_W + 1;
   localparam int SqSteps  = RootW;
   localparam int DivSteps = QuoW;

   // stage 1: or of magnitudes
   logic                 v1_ff;
   logic [2:0][MagW-1:0] a1_ff;
   logic [2:0]           n1_ff;
   logic [TagW-1:0]      t1_ff;
   logic [MagW-1:0]      or1_ff;

   // stage 2: leading one position
   logic                 v2_ff;
   logic [2:0][MagW-1:0] a2_ff;
   logic [2:0]           n2_ff;
   logic [TagW-1:0]      t2_ff;
   logic [PosW-1:0]      pos2_ff;
   logic [PosW-1:0]      pos2_in;

   // stage 3: normalized magnitudes
   logic                   v3_ff;
   logic [2:0][NORM_W-1:0] s3_ff;
   logic [2:0][NORM_W-1:0] s3_in;
   logic [2:0]             n3_ff;
   logic [TagW-1:0]        t3_ff;

   // stage 4: squares
   logic                   v4_ff;
   logic [2:0][NORM_W-1:0] s4_ff;
   logic [2:0][SqW-1:0]    q4_ff;
   logic [2:0]             n4_ff;
   logic [TagW-1:0]        t4_ff;

   // square root stages, index 0 holds the sum
   logic                   sq_v_ff    [SqSteps+1];
   logic [RemW-1:0]        sq_rem_ff  [SqSteps+1];
   logic [RootW-1:0]       sq_root_ff [SqSteps+1];
   logic [SumW-1:0]        sq_n_ff    [SqSteps+1];
   logic [2:0][NORM_W-1:0] sq_s_ff    [SqSteps+1];
   logic [2:0]             sq_neg_ff  [SqSteps+1];
   logic [TagW-1:0]        sq_tag_ff  [SqSteps+1];

   // divide stages, index 0 holds the rounded numerators
   logic                  dv_v_ff    [DivSteps+1];
   logic [RootW-1:0]      dv_len_ff  [DivSteps+1];
   logic [2:0][NumW-1:0]  dv_num_ff  [DivSteps+1];
   logic [2:0][RootW-1:0] dv_rem_ff  [DivSteps+1];
   logic [2:0][QuoW-1:0]  dv_q_ff    [DivSteps+1];
   logic [2:0]            dv_neg_ff  [DivSteps+1];
   logic [TagW-1:0]       dv_tag_ff  [DivSteps+1];

   logic [2:0][NumW-1:0]  num_in;
   logic [2:0][RootW-1:0] rem0_in;

   // output stage
   logic            vo_ff;
   unit_vec_type    uo_ff;
   unit_vec_type    uo_in;
   logic [TagW-1:0] to_ff;

   always_comb begin
      pos2_in = '0;
      for (int i = 0; i < MagW; i++) begin
         if (or1_ff[i]) pos2_in = PosW'(i);
      end
   end

   always_comb begin
      logic [WideW-1:0] wide;
      for (int i = 0; i < 3; i++) begin
         wide     = {a2_ff[i], {(NORM_W-1){1'b0}}} >> pos2_ff;
         s3_in[i] = wide[NORM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         sq_v_ff[0] <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         sq_v_ff[0] <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a1_ff  <= in_mag;
         n1_ff  <= in_neg;
         t1_ff  <= in_tag;
         or1_ff <= in_mag[0] | in_mag[1] | in_mag[2];
         a2_ff   <= a1_ff;
         n2_ff   <= n1_ff;
         t2_ff   <= t1_ff;
         pos2_ff <= pos2_in;
         s3_ff <= s3_in;
         n3_ff <= n2_ff;
         t3_ff <= t2_ff;
         s4_ff <= s3_ff;
         n4_ff <= n3_ff;
         t4_ff <= t3_ff;
         for (int i = 0; i < 3; i++) begin
            q4_ff[i] <= SqW'(s3_ff[i]) * SqW'(s3_ff[i]);
         end
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
         sq_n_ff[0]    <= SumW'(q4_ff[0]) + SumW'(q4_ff[1]) + SumW'(q4_ff[2]);
         sq_s_ff[0]    <= s4_ff;
         sq_neg_ff[0]  <= n4_ff;
         sq_tag_ff[0]  <= t4_ff;
      end
   end

   // one root bit per stage
   for (genvar k = 1; k <= SqSteps; k++) begin : g_sq
      logic [RemW-1:0]  rem_t;
      logic [RemW-1:0]  trial;
      logic [RemW-1:0]  rem_in;
      logic [RootW-1:0] root_in;

      always_comb begin
         rem_t = {sq_rem_ff[k-1][RemW-3:0], sq_n_ff[k-1][SumW-1 -: 2]};
         trial = RemW'({sq_root_ff[k-1], 2'b01});
         if (rem_t >= trial) begin
            rem_in  = rem_t - trial;
            root_in = {sq_root_ff[k-1][RootW-2:0], 1'b1};
         end else begin
            rem_in  = rem_t;
            root_in = {sq_root_ff[k-1][RootW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k] <= 1'b0;
         end else if (adv) begin
            sq_v_ff[k] <= sq_v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_rem_ff[k]  <= rem_in;
            sq_root_ff[k] <= root_in;
            sq_n_ff[k]    <= {sq_n_ff[k-1][SumW-3:0], 2'b00};
            sq_s_ff[k]    <= sq_s_ff[k-1];
            sq_neg_ff[k]  <= sq_neg_ff[k-1];
            sq_tag_ff[k]  <= sq_tag_ff[k-1];
         end
      end
   end

   // numerator |c| * 2^16 + len / 2
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num_in[i]  = NumW'({sq_s_ff[SqSteps][i], {FRAC_W{1'b0}}})
                    + NumW'(sq_root_ff[SqSteps] >> 1);
         rem0_in[i] = RootW'(num_in[i][NumW-1:QuoW]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_v_ff[0] <= sq_v_ff[SqSteps];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_len_ff[0] <= sq_root_ff[SqSteps];
         dv_num_ff[0] <= num_in;
         dv_rem_ff[0] <= rem0_in;
         dv_q_ff[0]   <= '0;
         dv_neg_ff[0] <= sq_neg_ff[SqSteps];
         dv_tag_ff[0] <= sq_tag_ff[SqSteps];
      end
   end

   // one quotient bit per stage, three lanes
   for (genvar k = 1; k <= DivSteps; k++) begin : g_dv
      logic [2:0][RootW-1:0] rem_in;
      logic [2:0][QuoW-1:0]  q_in;

      always_comb begin
         logic [RootW:0] rt;
         logic [RootW:0] diff;
         logic           ge;
         for (int i = 0; i < 3; i++) begin
            rt        = {dv_rem_ff[k-1][i], dv_num_ff[k-1][i][QuoW-k]};
            diff      = rt - {1'b0, dv_len_ff[k-1]};
            ge        = (rt >= {1'b0, dv_len_ff[k-1]});
            rem_in[i] = ge ? diff[RootW-1:0] : rt[RootW-1:0];
            q_in[i]   = {dv_q_ff[k-1][i][QuoW-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[k] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[k] <= dv_v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_len_ff[k] <= dv_len_ff[k-1];
            dv_num_ff[k] <= dv_num_ff[k-1];
            dv_rem_ff[k] <= rem_in;
            dv_q_ff[k]   <= q_in;
            dv_neg_ff[k] <= dv_neg_ff[k-1];
            dv_tag_ff[k] <= dv_tag_ff[k-1];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         uo_in[i] = dv_neg_ff[DivSteps][i] ? UNIT_W'(0) - UNIT_W'(dv_q_ff[DivSteps][i])
                                           : UNIT_W'(dv_q_ff[DivSteps][i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (adv) begin
         vo_ff <= dv_v_ff[DivSteps];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         uo_ff <= uo_in;
         to_ff <= dv_tag_ff[DivSteps];
      end
   end

   assign out_valid = vo_ff;
   assign out_unit  = uo_ff;
   assign out_tag   = to_ff;

endmodule
`default_nettype wire

/* hw/rtl/look_at_view_matrix.sv */
`timescale 1ns / 1ps
`default_nettype none
// the first row word of a camera leaves the row sequencer once its input word has passed
//   every pipeline stage; the following rows come one per cycle while the result port is ready
// throughput: one input word per four result words (one per cycle for a degenerate camera
//   while the result port is ready), set by the result port carrying one matrix row per word
// reset clears the valid bits of every stage and the row sequencer, no data reset
module look_at_view_matrix (
   input  wire logic clock,
   input  wire logic reset,
   lav_req_if.sink   req_chan,
   lav_rsp_if.source rsp_chan
);
   import lav_pkg::*;

   localparam int D_W     = DATA_W + 1;          // target - eye
   localparam int P1_W    = UNIT_W + DATA_W;     // forward * world up
   localparam int C_W     = P1_W + 1;            // cross product q32.32
   localparam int SSQ_W   = 2 * SMALL_W;
   localparam int TAG1_W  = 1 + 6 * DATA_W;
   localparam int TAG2_W  = 1 + 3 * UNIT_W + 3 * DATA_W;
   localparam int PR_W    = 2 * UNIT_W;          // right * forward
   localparam int UPD_W   = PR_W + 1;
   localparam int DP_W    = UNIT_W + DATA_W;     // unit * eye
   localparam int DS_W    = DP_W + 2;
   localparam int U_W     = FRAC_W + 3;          // rounded up' component
   localparam int UE_W    = U_W + DATA_W;
   localparam int DUE_W   = UE_W + 2;
   localparam int MAG_W   = 53;                  // common width for rounding
   localparam int TR_W    = MAG_W - FRAC_W + 1;

   // q32.32 magnitude to q16.16, ties away from zero, sign restored
   function automatic logic signed [TR_W-1:0] round_q(input logic [MAG_W-1:0] m,
                                                      input logic neg);
      logic [MAG_W:0]  t;
      logic [TR_W-1:0] r;
      t = ((MAG_W+1)'(m) + (MAG_W+1)'(RND_HALF)) >> FRAC_W;
      r = t[TR_W-1:0];
      return neg ? $signed(TR_W'(0) - r) : $signed(r);
   endfunction

   function automatic logic [MAG_W-1:0] mag_q(input logic signed [MAG_W-1:0] v);
      return v[MAG_W-1] ? MAG_W'(0) - MAG_W'(v) : MAG_W'(v);
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_q(input logic signed [TR_W-1:0] v);
      logic signed [TR_W-1:0] hi;
      logic signed [TR_W-1:0] lo;
      hi = TR_W'({1'b0, {(DATA_W-1){1'b1}}});
      lo = -hi - TR_W'(1);
      if (v > hi) return $signed({1'b0, {(DATA_W-1){1'b1}}});
      if (v < lo) return $signed({1'b1, {(DATA_W-1){1'b0}}});
      return $signed(v[DATA_W-1:0]);
   endfunction

   logic adv;

   // input register
   logic                     s0_v_ff;
   logic signed [DATA_W-1:0] s0_eye_ff [3];
   logic signed [DATA_W-1:0] s0_tgt_ff [3];
   logic signed [DATA_W-1:0] s0_wup_ff [3];

   // difference
   logic                     sa_v_ff;
   logic signed [D_W-1:0]    sa_d_ff   [3];
   logic signed [DATA_W-1:0] sa_eye_ff [3];
   logic signed [DATA_W-1:0] sa_wup_ff [3];

   logic [2:0][D_MAG_W-1:0] u1_mag;
   logic [2:0]              u1_neg;
   logic [TAG1_W-1:0]       u1_tag;
   logic                    u1_out_v;
   unit_vec_type            u1_f;
   logic [TAG1_W-1:0]       u1_out_tag;

   // forward x world up products
   logic                     sb_v_ff;
   logic signed [P1_W-1:0]   sb_p_ff   [6];
   unit_vec_type             sb_f_ff;
   logic signed [DATA_W-1:0] sb_eye_ff [3];
   logic                     sb_degf_ff;
   logic signed [DATA_W-1:0] u1_wup    [3];
   logic signed [UNIT_W-1:0] u1_fs     [3];

   // cross product
   logic                     sc_v_ff;
   logic signed [C_W-1:0]    sc_c_ff   [3];
   unit_vec_type             sc_f_ff;
   logic signed [DATA_W-1:0] sc_eye_ff [3];
   logic                     sc_degf_ff;

   // magnitudes and small squares
   logic                     sd_v_ff;
   logic [2:0][C_MAG_W-1:0]  sd_mag_ff;
   logic [2:0]               sd_neg_ff;
   logic                     sd_small_ff;
   logic [SSQ_W-1:0]         sd_sq_ff  [3];
   unit_vec_type             sd_f_ff;
   logic signed [DATA_W-1:0] sd_eye_ff [3];
   logic                     sd_degf_ff;
   logic [2:0][C_MAG_W-1:0]  sd_mag_in;

   // zero length check of right
   logic                     se_v_ff;
   logic [2:0][C_MAG_W-1:0]  se_mag_ff;
   logic [2:0]               se_neg_ff;
   logic                     se_degen_ff;
   unit_vec_type             se_f_ff;
   logic signed [DATA_W-1:0] se_eye_ff [3];

   logic [TAG2_W-1:0]        u2_tag;
   logic                     u2_out_v;
   unit_vec_type             u2_r;
   logic [TAG2_W-1:0]        u2_out_tag;
   logic signed [UNIT_W-1:0] u2_rs     [3];
   logic signed [UNIT_W-1:0] u2_fs     [3];
   logic signed [DATA_W-1:0] u2_eye    [3];

   // up' products and dot products with eye
   logic                     sf_v_ff;
   logic signed [PR_W-1:0]   sf_pr_ff  [6];
   logic signed [DP_W-1:0]   sf_re_ff  [3];
   logic signed [DP_W-1:0]   sf_fe_ff  [3];
   unit_vec_type             sf_r_ff;
   unit_vec_type             sf_f_ff;
   logic signed [DATA_W-1:0] sf_eye_ff [3];
   logic                     sf_degen_ff;

   // sums
   logic                     sg_v_ff;
   logic signed [UPD_W-1:0]  sg_up_ff  [3];
   logic signed [DS_W-1:0]   sg_dr_ff;
   logic signed [DS_W-1:0]   sg_df_ff;
   unit_vec_type             sg_r_ff;
   unit_vec_type             sg_f_ff;
   logic signed [DATA_W-1:0] sg_eye_ff [3];
   logic                     sg_degen_ff;

   // magnitudes for rounding
   logic                     sh_v_ff;
   logic [MAG_W-1:0]         sh_upm_ff [3];
   logic [2:0]               sh_upn_ff;
   logic [MAG_W-1:0]         sh_m0_ff;
   logic                     sh_n0_ff;
   logic [MAG_W-1:0]         sh_m2_ff;
   logic                     sh_n2_ff;
   unit_vec_type             sh_r_ff;
   unit_vec_type             sh_f_ff;
   logic signed [DATA_W-1:0] sh_eye_ff [3];
   logic                     sh_degen_ff;

   // rounded up' and translations
   logic                     si_v_ff;
   logic signed [U_W-1:0]    si_u_ff   [3];
   logic signed [TR_W-1:0]   si_t0_ff;
   logic signed [TR_W-1:0]   si_t2_ff;
   unit_vec_type             si_r_ff;
   unit_vec_type             si_f_ff;
   logic signed [DATA_W-1:0] si_eye_ff [3];
   logic                     si_degen_ff;

   // up' * eye
   logic                     sj_v_ff;
   logic signed [UE_W-1:0]   sj_ue_ff  [3];
   logic signed [DATA_W-1:0] sj_t0_ff;
   logic signed [DATA_W-1:0] sj_t2_ff;
   logic signed [U_W-1:0]    sj_u_ff   [3];
   unit_vec_type             sj_r_ff;
   unit_vec_type             sj_f_ff;
   logic                     sj_degen_ff;

   // dot(up', eye) sum, magnitude, round, saturate
   logic                     sk_v_ff;
   logic signed [DUE_W-1:0]  sk_du_ff;
   logic                     sl_v_ff;
   logic [MAG_W-1:0]         sl_m1_ff;
   logic                     sl_n1_ff;
   logic                     sm_v_ff;
   logic signed [TR_W-1:0]   sm_t1_ff;
   logic                     sn_v_ff;
   logic signed [DATA_W-1:0] sn_t1_ff;

   // t0, t2, rows carried alongside
   logic signed [DATA_W-1:0] sk_t0_ff, sl_t0_ff, sm_t0_ff, sn_t0_ff;
   logic signed [DATA_W-1:0] sk_t2_ff, sl_t2_ff, sm_t2_ff, sn_t2_ff;
   logic signed [U_W-1:0]    sk_u_ff [3], sl_u_ff [3], sm_u_ff [3], sn_u_ff [3];
   unit_vec_type             sk_r_ff, sl_r_ff, sm_r_ff, sn_r_ff;
   unit_vec_type             sk_f_ff, sl_f_ff, sm_f_ff, sn_f_ff;
   logic                     sk_degen_ff, sl_degen_ff, sm_degen_ff, sn_degen_ff;

   // row sequencer
   logic                     ser_v_ff;
   row_type                  ser_row_ff;
   logic signed [DATA_W-1:0] ser_t_ff  [3];
   logic signed [U_W-1:0]    ser_u_ff  [3];
   unit_vec_type             ser_r_ff;
   unit_vec_type             ser_f_ff;
   logic                     ser_degen_ff;
   logic                     ser_last;
   logic                     ser_done;
   logic                     ser_take;

   // whole pipe moves together, held only when the last stage cannot hand off
   assign ser_last = ser_degen_ff || (ser_row_ff == ROW_W);
   assign ser_done = ser_v_ff && rsp_chan.ready && ser_last;
   assign ser_take = !ser_v_ff || ser_done;
   assign adv      = !sn_v_ff || ser_take;

   assign req_chan.ready = adv;

   // ---- valid bits ----
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
         sa_v_ff <= 1'b0;
         sb_v_ff <= 1'b0;
         sc_v_ff <= 1'b0;
         sd_v_ff <= 1'b0;
         se_v_ff <= 1'b0;
         sf_v_ff <= 1'b0;
         sg_v_ff <= 1'b0;
         sh_v_ff <= 1'b0;
         si_v_ff <= 1'b0;
         sj_v_ff <= 1'b0;
         sk_v_ff <= 1'b0;
         sl_v_ff <= 1'b0;
         sm_v_ff <= 1'b0;
         sn_v_ff <= 1'b0;
      end else if (adv) begin
         s0_v_ff <= req_chan.valid;
         sa_v_ff <= s0_v_ff;
         sb_v_ff <= u1_out_v;
         sc_v_ff <= sb_v_ff;
         sd_v_ff <= sc_v_ff;
         se_v_ff <= sd_v_ff;
         sf_v_ff <= u2_out_v;
         sg_v_ff <= sf_v_ff;
         sh_v_ff <= sg_v_ff;
         si_v_ff <= sh_v_ff;
         sj_v_ff <= si_v_ff;
         sk_v_ff <= sj_v_ff;
         sl_v_ff <= sk_v_ff;
         sm_v_ff <= sl_v_ff;
         sn_v_ff <= sm_v_ff;
      end
   end

   // ---- input and difference ----
   always_ff @(posedge clock) begin
      if (adv) begin
         s0_eye_ff[0] <= req_chan.eye_x;
         s0_eye_ff[1] <= req_chan.eye_y;
         s0_eye_ff[2] <= req_chan.eye_z;
         s0_tgt_ff[0] <= req_chan.target_x;
         s0_tgt_ff[1] <= req_chan.target_y;
         s0_tgt_ff[2] <= req_chan.target_z;
         s0_wup_ff[0] <= req_chan.world_up_x;
         s0_wup_ff[1] <= req_chan.world_up_y;
         s0_wup_ff[2] <= req_chan.world_up_z;
         for (int i = 0; i < 3; i++) begin
            sa_d_ff[i]   <= D_W'(s0_tgt_ff[i]) - D_W'(s0_eye_ff[i]);
            sa_eye_ff[i] <= s0_eye_ff[i];
            sa_wup_ff[i] <= s0_wup_ff[i];
         end
      end
   end

   // ---- normalize target - eye ----
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         u1_neg[i] = sa_d_ff[i][D_W-1];
         u1_mag[i] = u1_neg[i] ? D_MAG_W'(0) - D_MAG_W'(sa_d_ff[i]) : D_MAG_W'(sa_d_ff[i]);
      end
      u1_tag = {(sa_d_ff[0] == '0) && (sa_d_ff[1] == '0) && (sa_d_ff[2] == '0),
                sa_eye_ff[0], sa_eye_ff[1], sa_eye_ff[2],
                sa_wup_ff[0], sa_wup_ff[1], sa_wup_ff[2]};
   end

   lav_unit #(
      .MagW (D_MAG_W),
      .TagW (TAG1_W)
   ) u_fwd (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sa_v_ff),
      .in_mag    (u1_mag),
      .in_neg    (u1_neg),
      .in_tag    (u1_tag),
      .out_valid (u1_out_v),
      .out_unit  (u1_f),
      .out_tag   (u1_out_tag)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         u1_fs[i]  = $signed(u1_f[i]);
         u1_wup[i] = $signed(u1_out_tag[(2-i)*DATA_W +: DATA_W]);
      end
   end

   // ---- forward x world up, degenerate right ----
   always_ff @(posedge clock) begin
      if (adv) begin
         sb_p_ff[0] <= P1_W'(u1_fs[1]) * P1_W'(u1_wup[2]);
         sb_p_ff[1] <= P1_W'(u1_fs[2]) * P1_W'(u1_wup[1]);
         sb_p_ff[2] <= P1_W'(u1_fs[2]) * P1_W'(u1_wup[0]);
         sb_p_ff[3] <= P1_W'(u1_fs[0]) * P1_W'(u1_wup[2]);
         sb_p_ff[4] <= P1_W'(u1_fs[0]) * P1_W'(u1_wup[1]);
         sb_p_ff[5] <= P1_W'(u1_fs[1]) * P1_W'(u1_wup[0]);
         sb_f_ff    <= u1_f;
         for (int i = 0; i < 3; i++) begin
            sb_eye_ff[i] <= $signed(u1_out_tag[(5-i)*DATA_W +: DATA_W]);
         end
         sb_degf_ff <= u1_out_tag[TAG1_W-1];

         for (int i = 0; i < 3; i++) begin
            sc_c_ff[i] <= C_W'(sb_p_ff[2*i]) - C_W'(sb_p_ff[2*i+1]);
         end
         sc_f_ff    <= sb_f_ff;
         sc_eye_ff  <= sb_eye_ff;
         sc_degf_ff <= sb_degf_ff;

         sd_mag_ff <= sd_mag_in;
         for (int i = 0; i < 3; i++) begin
            sd_neg_ff[i] <= sc_c_ff[i][C_W-1];
            sd_sq_ff[i]  <= SSQ_W'(sd_mag_in[i][SMALL_W-1:0])
                          * SSQ_W'(sd_mag_in[i][SMALL_W-1:0]);
         end
         sd_small_ff <= (sd_mag_in[0][C_MAG_W-1:SMALL_W] == '0)
                     && (sd_mag_in[1][C_MAG_W-1:SMALL_W] == '0)
                     && (sd_mag_in[2][C_MAG_W-1:SMALL_W] == '0);
         sd_f_ff    <= sc_f_ff;
         sd_eye_ff  <= sc_eye_ff;
         sd_degf_ff <= sc_degf_ff;

         se_mag_ff   <= sd_mag_ff;
         se_neg_ff   <= sd_neg_ff;
         se_degen_ff <= sd_degf_ff
                     || (sd_small_ff && ((SSUM_W'(sd_sq_ff[0]) + SSUM_W'(sd_sq_ff[1])
                                          + SSUM_W'(sd_sq_ff[2])) <= RIGHT_EPS_SQ));
         se_f_ff     <= sd_f_ff;
         se_eye_ff   <= sd_eye_ff;
      end
   end

   always_comb begin
      logic [C_W-1:0] m;
      for (int i = 0; i < 3; i++) begin
         m            = sc_c_ff[i][C_W-1] ? C_W'(0) - C_W'(sc_c_ff[i]) : C_W'(sc_c_ff[i]);
         sd_mag_in[i] = m[C_MAG_W-1:0];
      end
   end

   // ---- normalize right ----
   assign u2_tag = {se_degen_ff, se_f_ff, se_eye_ff[0], se_eye_ff[1], se_eye_ff[2]};

   lav_unit #(
      .MagW (C_MAG_W),
      .TagW (TAG2_W)
   ) u_right (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (se_v_ff),
      .in_mag    (se_mag_ff),
      .in_neg    (se_neg_ff),
      .in_tag    (u2_tag),
      .out_valid (u2_out_v),
      .out_unit  (u2_r),
      .out_tag   (u2_out_tag)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         u2_rs[i]  = $signed(u2_r[i]);
         u2_fs[i]  = $signed(u2_out_tag[3*DATA_W + i*UNIT_W +: UNIT_W]);
         u2_eye[i] = $signed(u2_out_tag[(2-i)*DATA_W +: DATA_W]);
      end
   end

   // ---- up', dot products, rounding ----
   always_ff @(posedge clock) begin
      if (adv) begin
         sf_pr_ff[0] <= PR_W'(u2_rs[1]) * PR_W'(u2_fs[2]);
         sf_pr_ff[1] <= PR_W'(u2_rs[2]) * PR_W'(u2_fs[1]);
         sf_pr_ff[2] <= PR_W'(u2_rs[2]) * PR_W'(u2_fs[0]);
         sf_pr_ff[3] <= PR_W'(u2_rs[0]) * PR_W'(u2_fs[2]);
         sf_pr_ff[4] <= PR_W'(u2_rs[0]) * PR_W'(u2_fs[1]);
         sf_pr_ff[5] <= PR_W'(u2_rs[1]) * PR_W'(u2_fs[0]);
         for (int i = 0; i < 3; i++) begin
            sf_re_ff[i]  <= DP_W'(u2_rs[i]) * DP_W'(u2_eye[i]);
            sf_fe_ff[i]  <= DP_W'(u2_fs[i]) * DP_W'(u2_eye[i]);
            sf_eye_ff[i] <= u2_eye[i];
         end
         sf_r_ff     <= u2_r;
         sf_f_ff     <= u2_out_tag[3*DATA_W +: 3*UNIT_W];
         sf_degen_ff <= u2_out_tag[TAG2_W-1];

         for (int i = 0; i < 3; i++) begin
            sg_up_ff[i] <= UPD_W'(sf_pr_ff[2*i]) - UPD_W'(sf_pr_ff[2*i+1]);
         end
         sg_dr_ff    <= DS_W'(sf_re_ff[0]) + DS_W'(sf_re_ff[1]) + DS_W'(sf_re_ff[2]);
         sg_df_ff    <= DS_W'(sf_fe_ff[0]) + DS_W'(sf_fe_ff[1]) + DS_W'(sf_fe_ff[2]);
         sg_r_ff     <= sf_r_ff;
         sg_f_ff     <= sf_f_ff;
         sg_eye_ff   <= sf_eye_ff;
         sg_degen_ff <= sf_degen_ff;

         for (int i = 0; i < 3; i++) begin
            sh_upm_ff[i] <= mag_q(MAG_W'(sg_up_ff[i]));
            sh_upn_ff[i] <= sg_up_ff[i][UPD_W-1];
         end
         // row 0 carries -dot(right, eye)
         sh_m0_ff    <= mag_q(MAG_W'(sg_dr_ff));
         sh_n0_ff    <= (sg_dr_ff > 0);
         sh_m2_ff    <= mag_q(MAG_W'(sg_df_ff));
         sh_n2_ff    <= sg_df_ff[DS_W-1];
         sh_r_ff     <= sg_r_ff;
         sh_f_ff     <= sg_f_ff;
         sh_eye_ff   <= sg_eye_ff;
         sh_degen_ff <= sg_degen_ff;

         for (int i = 0; i < 3; i++) begin
            si_u_ff[i] <= U_W'(round_q(sh_upm_ff[i], sh_upn_ff[i]));
         end
         si_t0_ff    <= round_q(sh_m0_ff, sh_n0_ff);
         si_t2_ff    <= round_q(sh_m2_ff, sh_n2_ff);
         si_r_ff     <= sh_r_ff;
         si_f_ff     <= sh_f_ff;
         si_eye_ff   <= sh_eye_ff;
         si_degen_ff <= sh_degen_ff;

         for (int i = 0; i < 3; i++) begin
            sj_ue_ff[i] <= UE_W'(si_u_ff[i]) * UE_W'(si_eye_ff[i]);
         end
         sj_t0_ff    <= sat_q(si_t0_ff);
         sj_t2_ff    <= sat_q(si_t2_ff);
         sj_u_ff     <= si_u_ff;
         sj_r_ff     <= si_r_ff;
         sj_f_ff     <= si_f_ff;
         sj_degen_ff <= si_degen_ff;

         sk_du_ff <= DUE_W'(sj_ue_ff[0]) + DUE_W'(sj_ue_ff[1]) + DUE_W'(sj_ue_ff[2]);
         // row 1 carries -dot(up', eye)
         sl_m1_ff <= mag_q(MAG_W'(sk_du_ff));
         sl_n1_ff <= (sk_du_ff > 0);
         sm_t1_ff <= round_q(sl_m1_ff, sl_n1_ff);
         sn_t1_ff <= sat_q(sm_t1_ff);

         sk_t0_ff <= sj_t0_ff;     sl_t0_ff <= sk_t0_ff;
         sm_t0_ff <= sl_t0_ff;     sn_t0_ff <= sm_t0_ff;
         sk_t2_ff <= sj_t2_ff;     sl_t2_ff <= sk_t2_ff;
         sm_t2_ff <= sl_t2_ff;     sn_t2_ff <= sm_t2_ff;
         sk_u_ff  <= sj_u_ff;      sl_u_ff  <= sk_u_ff;
         sm_u_ff  <= sl_u_ff;      sn_u_ff  <= sm_u_ff;
         sk_r_ff  <= sj_r_ff;      sl_r_ff  <= sk_r_ff;
         sm_r_ff  <= sl_r_ff;      sn_r_ff  <= sm_r_ff;
         sk_f_ff  <= sj_f_ff;      sl_f_ff  <= sk_f_ff;
         sm_f_ff  <= sl_f_ff;      sn_f_ff  <= sm_f_ff;
         sk_degen_ff <= sj_degen_ff;
         sl_degen_ff <= sk_degen_ff;
         sm_degen_ff <= sl_degen_ff;
         sn_degen_ff <= sm_degen_ff;
      end
   end

   // ---- row sequencer: one result word per matrix row, a single word for a degenerate camera ----
   always_ff @(posedge clock) begin
      if (reset) begin
         ser_v_ff   <= 1'b0;
         ser_row_ff <= ROW_RIGHT;
      end else if (ser_take) begin
         ser_v_ff   <= sn_v_ff;
         ser_row_ff <= ROW_RIGHT;
      end else if (ser_v_ff && rsp_chan.ready) begin
         ser_row_ff <= row_type'(ser_row_ff + 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (ser_take) begin
         ser_t_ff[0]  <= sn_t0_ff;
         ser_t_ff[1]  <= sn_t1_ff;
         ser_t_ff[2]  <= sn_t2_ff;
         ser_u_ff     <= sn_u_ff;
         ser_r_ff     <= sn_r_ff;
         ser_f_ff     <= sn_f_ff;
         ser_degen_ff <= sn_degen_ff;
      end
   end

   always_comb begin
      rsp_chan.valid      = ser_v_ff;
      rsp_chan.row_index  = ser_row_ff;
      rsp_chan.last_row   = ser_last;
      rsp_chan.degenerate = ser_degen_ff;
      rsp_chan.col0       = '0;
      rsp_chan.col1       = '0;
      rsp_chan.col2       = '0;
      rsp_chan.col3       = '0;
      if (!ser_degen_ff) begin
         unique case (ser_row_ff)
            ROW_RIGHT: begin
               rsp_chan.col0 = DATA_W'($signed(ser_r_ff[0]));
               rsp_chan.col1 = DATA_W'($signed(ser_r_ff[1]));
               rsp_chan.col2 = DATA_W'($signed(ser_r_ff[2]));
               rsp_chan.col3 = ser_t_ff[0];
            end
            ROW_UP: begin
               rsp_chan.col0 = DATA_W'(ser_u_ff[0]);
               rsp_chan.col1 = DATA_W'(ser_u_ff[1]);
               rsp_chan.col2 = DATA_W'(ser_u_ff[2]);
               rsp_chan.col3 = ser_t_ff[1];
            end
            ROW_FWD: begin
               rsp_chan.col0 = DATA_W'(0) - DATA_W'($signed(ser_f_ff[0]));
               rsp_chan.col1 = DATA_W'(0) - DATA_W'($signed(ser_f_ff[1]));
               rsp_chan.col2 = DATA_W'(0) - DATA_W'($signed(ser_f_ff[2]));
               rsp_chan.col3 = ser_t_ff[2];
            end
            ROW_W: begin
               rsp_chan.col3 = ONE_Q16;
            end
            default: begin
               rsp_chan.col3 = '0;
            end
         endcase
      end
   end

endmodule
`default_nettype wire
